FILE: design/tes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and codes of the timer event scheduler.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_REG  = 2'd1;
  localparam logic [1:0] FUNC_SET  = 2'd2;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_FIRED = 2'd2;

  localparam logic [1:0] MODE_ONESHOT = 2'd0;
  localparam logic [1:0] MODE_PERIOD  = 2'd1;
  localparam logic [1:0] MODE_UNTIL   = 2'd2;
  localparam logic [1:0] MODE_WHILE   = 2'd3;

  // due when now - when lies in [0, 2^31]
  localparam logic [31:0] DUE_LIMIT = 32'h8000_0000;

  // candidate handed along the chain during a scan
  typedef struct packed {
    logic        found;
    logic [31:0] key;
    logic [1:0]  mode;
  } cand_t;

  // broadcast command to the cells
  typedef struct packed {
    logic        wr;
    logic        fire;
    logic        set_flag;
    logic        keep;
    logic [1:0]  mode;
    logic [31:0] when;
    logic [19:0] period;
    logic [31:0] end_time;
  } cell_cmd_t;

endpackage
`default_nettype wire

FILE: design/tes_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tes_cell
// One timer slot plus one stage of the earliest-deadline search chain.
// ----------------------------------------------------------------------------
module tes_cell
  import tes_pkg::*;
#(
  parameter int IDX      = 0,
  parameter int SLOT_W   = 4,
  parameter int TAG_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [31:0]         now,
  input  wire cell_cmd_t           cmd,
  input  wire logic [SLOT_W-1:0]   cmd_idx,
  input  wire logic [TAG_BITS-1:0] wr_tag,
  input  wire cand_t               cand_in,
  input  wire logic [SLOT_W-1:0]   idx_in,
  input  wire logic [TAG_BITS-1:0] tag_in,
  output cand_t                    cand_out,
  output logic [SLOT_W-1:0]        idx_out,
  output logic [TAG_BITS-1:0]      tag_out,
  output logic                     valid_o
);

  logic                valid_r;
  logic [1:0]          mode_r;
  logic [31:0]         when_r;
  logic [19:0]         period_r;
  logic [31:0]         until_r;
  logic [TAG_BITS-1:0] tag_r;
  logic                cont_r;
  cand_t               cand_r;
  logic [SLOT_W-1:0]   idx_r;
  logic [TAG_BITS-1:0] ctag_r;

  logic        sel;
  logic [31:0] next_when;
  logic [31:0] until_diff;
  logic        rearm;
  logic [31:0] key;
  logic        win;

  assign sel        = (cmd_idx == SLOT_W'(IDX));
  assign next_when  = now + 32'(period_r);
  assign until_diff = next_when - until_r;
  assign key        = now - when_r;
  assign win        = valid_r && (key <= DUE_LIMIT) &&
                      (!cand_in.found || key > cand_in.key);

  always_comb begin
    case (mode_r)
      MODE_PERIOD: rearm = 1'b1;
      MODE_UNTIL:  rearm = (until_diff == 32'd0) || until_diff[31];
      MODE_WHILE:  rearm = cont_r;
      default:     rearm = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.wr && sel) begin
      valid_r <= 1'b1;
    end else if (cmd.fire && sel && !rearm) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && sel) begin
      mode_r   <= cmd.mode;
      when_r   <= cmd.when;
      period_r <= cmd.period;
      until_r  <= cmd.end_time;
      tag_r    <= wr_tag;
      cont_r   <= cmd.keep;
    end else begin
      if (cmd.set_flag && sel) begin
        cont_r <= cmd.keep;
      end
      if (cmd.fire && sel && rearm) begin
        when_r <= next_when;
      end
    end
  end

  // search stage: keep the incoming candidate unless this slot is due and more overdue
  always_ff @(posedge clk) begin
    if (win) begin
      cand_r <= '{found: 1'b1, key: key, mode: mode_r};
      idx_r  <= SLOT_W'(IDX);
      ctag_r <= tag_r;
    end else begin
      cand_r <= cand_in;
      idx_r  <= idx_in;
      ctag_r <= tag_in;
    end
  end

  assign cand_out = cand_r;
  assign idx_out  = idx_r;
  assign tag_out  = ctag_r;
  assign valid_o  = valid_r;

endmodule
`default_nettype wire

FILE: design/timer_event_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer_event_scheduler
// Table of software timers on a wrapping millisecond clock.
// ----------------------------------------------------------------------------
// A request on tuser 0 ticks the clock by one, 1 registers a timer in the
// lowest free slot (one result: registered or full), 2 sets a slot's continue
// flag. Each slot lives in a cell of a chain; a search pass moves a candidate
// through all NUM_SLOTS cells, one per cycle, picking the most overdue timer
// (lowest slot on ties). Register and set-flag requests are handled in the idle
// state. A tick runs one search pass, plus one more pass for every timer that
// fires, plus any output stall; each fired result is held back one pass so
// tlast can mark the final one. Requests are taken only while idle.
// ----------------------------------------------------------------------------
module timer_event_scheduler
  import tes_pkg::*;
#(
  parameter int NUM_SLOTS = 16,
  parameter int TAG_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // timer_mode[1:0] deadline[33:2] period[53:34] tag[69:54] slot[73:70]
  // keep_going[74], zero pad to 80
  input  wire logic [79:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // slot_out[3:0] mode_out[5:4] tag_out[21:6], zero pad to 24
  output logic [23:0]      out_tdata,
  // kind[1:0]
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // request fields
  logic [1:0]  f_mode;
  logic [31:0] f_deadline;
  logic [19:0] f_period;
  logic [15:0] f_tag;
  logic [3:0]  f_slot;
  logic        f_keep;
  logic [19:0] period_eff;

  assign f_mode     = in_tdata[1:0];
  assign f_deadline = in_tdata[33:2];
  assign f_period   = in_tdata[53:34];
  assign f_tag      = in_tdata[69:54];
  assign f_slot     = in_tdata[73:70];
  assign f_keep     = in_tdata[74];
  assign period_eff = (f_period == 20'd0) ? 20'd1 : f_period;

  state_t              state_r, state_nxt;
  logic [31:0]         now_r;
  logic [SLOT_W-1:0]   cnt_r, cnt_nxt;

  // result being held until the next pass tells whether it is the last one
  logic                pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic [1:0]          pend_mode_r, pend_mode_nxt;
  logic [TAG_BITS-1:0] pend_tag_r, pend_tag_nxt;

  // output register
  logic        out_v_r, out_v_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [3:0]  out_slot_r, out_slot_nxt;
  logic [1:0]  out_mode_r, out_mode_nxt;
  logic [15:0] out_tag_r, out_tag_nxt;
  logic        out_last_r, out_last_nxt;

  logic                in_acc;
  logic                out_ok;
  cell_cmd_t           cmd;
  logic [SLOT_W-1:0]   cmd_idx;
  logic [TAG_BITS-1:0] wr_tag;

  cand_t               ch_cand [NUM_SLOTS+1];
  logic [SLOT_W-1:0]   ch_idx  [NUM_SLOTS+1];
  logic [TAG_BITS-1:0] ch_tag  [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] valid_vec;

  logic              full;
  logic [SLOT_W-1:0] free_idx;

  assign out_ok    = !out_v_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_ok;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_tag    = TAG_BITS'(32'(f_tag));

  // lowest free slot
  always_comb begin
    full     = 1'b1;
    free_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_vec[i]) begin
        full     = 1'b0;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // chain head: empty candidate
  assign ch_cand[0] = '0;
  assign ch_idx[0]  = '0;
  assign ch_tag[0]  = '0;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    tes_cell #(
      .IDX      (g),
      .SLOT_W   (SLOT_W),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .now      (now_r),
      .cmd      (cmd),
      .cmd_idx  (cmd_idx),
      .wr_tag   (wr_tag),
      .cand_in  (ch_cand[g]),
      .idx_in   (ch_idx[g]),
      .tag_in   (ch_tag[g]),
      .cand_out (ch_cand[g+1]),
      .idx_out  (ch_idx[g+1]),
      .tag_out  (ch_tag[g+1]),
      .valid_o  (valid_vec[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_mode_nxt = pend_mode_r;
    pend_tag_nxt  = pend_tag_r;
    out_v_nxt     = out_v_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_mode_nxt  = out_mode_r;
    out_tag_nxt   = out_tag_r;
    out_last_nxt  = out_last_r;

    cmd           = '0;
    cmd.keep      = f_keep;
    cmd.mode      = f_mode;
    cmd.when      = (f_mode == MODE_ONESHOT) ? f_deadline : now_r + 32'(period_eff);
    cmd.period    = period_eff;
    cmd.end_time  = f_deadline;
    cmd_idx       = free_idx;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            FUNC_TICK: begin
              state_nxt = ST_SCAN;
              cnt_nxt   = SLOT_W'(NUM_SLOTS - 1);
            end
            FUNC_REG: begin
              cmd.wr       = !full;
              out_v_nxt    = 1'b1;
              out_kind_nxt = full ? KIND_FULL : KIND_REG;
              out_slot_nxt = full ? 4'd0 : 4'(32'(free_idx));
              out_mode_nxt = f_mode;
              out_tag_nxt  = 16'(32'(wr_tag));
              out_last_nxt = 1'b1;
            end
            FUNC_SET: begin
              cmd.set_flag = (32'(f_slot) < NUM_SLOTS);
              cmd_idx      = SLOT_W'(32'(f_slot));
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r - SLOT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_idx = ch_idx[NUM_SLOTS];
        if (!pend_v_r || out_ok) begin
          if (pend_v_r) begin
            out_v_nxt    = 1'b1;
            out_kind_nxt = KIND_FIRED;
            out_slot_nxt = 4'(32'(pend_slot_r));
            out_mode_nxt = pend_mode_r;
            out_tag_nxt  = 16'(32'(pend_tag_r));
            out_last_nxt = !ch_cand[NUM_SLOTS].found;
          end
          if (ch_cand[NUM_SLOTS].found) begin
            cmd.fire      = 1'b1;
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = ch_idx[NUM_SLOTS];
            pend_mode_nxt = ch_cand[NUM_SLOTS].mode;
            pend_tag_nxt  = ch_tag[NUM_SLOTS];
            state_nxt     = ST_SCAN;
            cnt_nxt       = SLOT_W'(NUM_SLOTS - 1);
          end else begin
            pend_v_nxt = 1'b0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      now_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      cnt_r    <= cnt_nxt;
      if (in_acc && in_tuser == FUNC_TICK) begin
        now_r <= now_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
    pend_mode_r <= pend_mode_nxt;
    pend_tag_r  <= pend_tag_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_mode_r  <= out_mode_nxt;
    out_tag_r   <= out_tag_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_tag_r, out_mode_r, out_slot_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

FILE: design/tes_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tes_checker
// Port-level checks of the timer event scheduler.
// ----------------------------------------------------------------------------
module tes_checker
  import tes_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  a_reg_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_REG || out_tuser == KIND_FULL) |-> out_tlast)
    else $error("register result not marked last");

  a_reg_answer: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == FUNC_REG |=>
      out_tvalid && (out_tuser == KIND_REG || out_tuser == KIND_FULL))
    else $error("register request without answer");

endmodule

bind timer_event_scheduler tes_checker u_tes_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the timer event scheduler: a directed table of
// requests followed by random register/tick/flag traffic, every result
// compared against a behavioural timer table kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
  import tes_pkg::*;

  localparam int SLOTS    = 16;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [1:0]  mode;
    logic [15:0] tag;
    logic        last;
  } fire_rec_t;

  typedef struct {
    logic [1:0]  func;
    logic [1:0]  mode;
    logic [31:0] deadline;
    logic [19:0] period;
    logic [15:0] tag;
    logic [3:0]  slot;
    logic        keep;
    logic        chk;    // typed-in expectation present
    logic [1:0]  x_kind;
    logic [3:0]  x_slot;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // behavioural copy of the timer table
  logic [31:0] clock_ms;
  logic        t_valid [SLOTS];
  logic [1:0]  t_mode  [SLOTS];
  logic [31:0] t_when  [SLOTS];
  logic [19:0] t_period[SLOTS];
  logic [31:0] t_until [SLOTS];
  logic [15:0] t_tag   [SLOTS];
  logic        t_keep  [SLOTS];

  fire_rec_t pending_fires[$];
  req_t      table_rows[$];
  int        mismatches = 0;
  int        n_results = 0, n_fired = 0, n_full = 0;
  int        idle_cycles = 0;
  bit        out_burst = 1'b0;
  bit        no_stall = 1'b0;

  timer_event_scheduler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // signed-difference compare: a is at or before b
  function automatic bit at_or_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d == 0) || d[31];
  endfunction

  // apply one request to the table and queue the results it causes
  task automatic predict_schedule(req_t r);
    logic [19:0] per;
    bit          done[SLOTS];
    int          best, first;
    logic [31:0] best_key, key, next;
    bit          rearm;
    per = (r.period == 0) ? 20'd1 : r.period;
    first = pending_fires.size();
    if (r.func == FUNC_TICK) begin
      foreach (done[i]) done[i] = 0;
      clock_ms = clock_ms + 1;
      forever begin
        best = -1;
        best_key = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!t_valid[i] || done[i] || !at_or_before(t_when[i], clock_ms)) continue;
          key = clock_ms - t_when[i];
          if (best < 0 || key > best_key) begin
            best = i;
            best_key = key;
          end
        end
        if (best < 0) break;
        done[best] = 1;
        pending_fires.push_back('{KIND_FIRED, best[3:0], t_mode[best], t_tag[best], 1'b0});
        next = clock_ms + t_period[best];
        case (t_mode[best])
          MODE_PERIOD: rearm = 1;
          MODE_UNTIL:  rearm = at_or_before(next, t_until[best]);
          MODE_WHILE:  rearm = t_keep[best];
          default:     rearm = 0;
        endcase
        if (rearm) t_when[best] = next;
        else t_valid[best] = 0;
      end
    end else if (r.func == FUNC_REG) begin
      best = -1;
      for (int i = 0; i < SLOTS; i++)
        if (!t_valid[i] && best < 0) best = i;
      if (best < 0) begin
        pending_fires.push_back('{KIND_FULL, 4'd0, r.mode, r.tag, 1'b0});
      end else begin
        t_valid[best]  = 1;
        t_mode[best]   = r.mode;
        t_when[best]   = (r.mode == MODE_ONESHOT) ? r.deadline : clock_ms + per;
        t_period[best] = per;
        t_until[best]  = r.deadline;
        t_tag[best]    = r.tag;
        t_keep[best]   = r.keep;
        pending_fires.push_back('{KIND_REG, best[3:0], r.mode, r.tag, 1'b0});
      end
    end else if (r.func == FUNC_SET) begin
      t_keep[r.slot] = r.keep;
    end
    if (pending_fires.size() > first)
      pending_fires[pending_fires.size() - 1].last = 1'b1;
  endtask

  // valid stays high straight into the next request when no gap is drawn
  task automatic send_request(req_t r);
    // random gap before the request, suppressed in the quiet stretch
    if (!no_stall && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!no_stall && $urandom_range(99) < 35);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, r.keep, r.slot, r.tag, r.period, r.deadline, r.mode};
    in_tuser  <= r.func;
    do @(posedge clk); while (!in_tready);
    predict_schedule(r);
    if (r.chk) begin
      // typed-in value must agree with the freshly queued result
      if (pending_fires.size() == 0 ||
          pending_fires[$].kind != r.x_kind || pending_fires[$].slot != r.x_slot) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row disagrees: expected kind %0d slot %0d", r.x_kind, r.x_slot);
      end
    end
  endtask

  function automatic req_t mk(logic [1:0] f, logic [1:0] m, logic [31:0] d,
                              logic [19:0] p, logic [15:0] t, logic [3:0] s,
                              logic k, logic c = 0, logic [1:0] xk = 0,
                              logic [3:0] xs = 0);
    req_t r;
    r = '{f, m, d, p, t, s, k, c, xk, xs};
    return r;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int   sel;
    sel = $urandom_range(99);
    r = mk(FUNC_TICK, 2'($urandom_range(3)), $urandom, 20'($urandom_range(6)),
           16'($urandom), 4'($urandom), 1'($urandom_range(1)));
    if (sel < 5) r.period = 20'($urandom);              // wide period bits
    if ($urandom_range(3) == 0) r.deadline = clock_ms + $urandom_range(12);
    else if ($urandom_range(2) == 0) r.deadline = clock_ms - $urandom_range(5);
    if (sel < 55) r.func = FUNC_TICK;
    else if (sel < 85) r.func = FUNC_REG;
    else if (sel < 97) r.func = FUNC_SET;
    else r.func = 2'd3;                                 // unused code
    return r;
  endfunction

  // result checker with random back-pressure
  always @(posedge clk) begin
    fire_rec_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[3:0], out_tdata[5:4], out_tdata[21:6], out_tlast};
        n_results++;
        if (got.kind == KIND_FIRED) n_fired++;
        if (got.kind == KIND_FULL) n_full++;
        if (pending_fires.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pending_fires.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      out_tready <= no_stall || ($urandom_range(99) >= 35);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !in_tvalid &&
        pending_fires.size() == 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int tail;
    clock_ms = 0;
    for (int i = 0; i < SLOTS; i++) begin
      t_valid[i] = 0; t_mode[i] = 0; t_when[i] = 0; t_period[i] = 0;
      t_until[i] = 0; t_tag[i] = 0; t_keep[i] = 0;
    end

    // directed table: typed-in slot/kind where obvious after reset
    table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));             // nothing due
    table_rows.push_back(mk(FUNC_REG, MODE_ONESHOT, 32'd0, 0, 16'hFFFF, 0, 0,
                            1, KIND_REG, 4'd0));                       // deadline past
    table_rows.push_back(mk(FUNC_REG, MODE_PERIOD, 32'hFFFF_FFFF, 20'd0, 16'h0000,
                            0, 0, 1, KIND_REG, 4'd1));                 // zero period
    table_rows.push_back(mk(FUNC_REG, MODE_UNTIL, 32'd6, 20'hFFFFF, 16'hA5A5, 0, 1,
                            1, KIND_REG, 4'd2));
    table_rows.push_back(mk(FUNC_REG, MODE_WHILE, 32'd0, 20'd2, 16'h5A5A, 0, 1,
                            1, KIND_REG, 4'd3));
    table_rows.push_back(mk(FUNC_REG, MODE_UNTIL, 32'd4, 20'd1, 16'h1234, 0, 0,
                            1, KIND_REG, 4'd4));
    table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk(FUNC_SET, 0, 0, 0, 0, 4'd3, 0));
    table_rows.push_back(mk(FUNC_SET, 0, 0, 0, 0, 4'd15, 1));          // free slot
    table_rows.push_back(mk(2'd3, 3, 32'hFFFF_FFFF, 20'hFFFFF, 16'hFFFF, 4'hF, 1));
    for (int i = 0; i < 4; i++) table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)                                        // fill, then full
      table_rows.push_back(mk(FUNC_REG, i[1:0], 32'd12, 20'd3, i[15:0], 0, 1));
    table_rows.push_back(mk(FUNC_TICK, 0, 0, 0, 0, 0, 0));              // only slot 1 is due

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) send_request(table_rows[i]);
    in_tvalid <= 1'b0;

    // hold the sender until the table has drained its results
    wait (pending_fires.size() == 0);
    repeat (40) @(posedge clk);

    for (int i = 0; i < 78; i++) begin
      no_stall = (i >= 40 && i < 60);
      send_request(rand_req());
    end
    in_tvalid <= 1'b0;
    no_stall = 0;

    wait (pending_fires.size() == 0);
    tail = 0;
    while (tail < 200 && !out_tvalid) begin
      @(posedge clk);
      tail++;
    end
    repeat (4) @(posedge clk);

    $display("Covered %0d results: %0d fired, %0d table-full; clock reached %0d ms.",
             n_results, n_fired, n_full, clock_ms);
    if (mismatches == 0 && pending_fires.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
